// ===== rtl/stg_pkg.sv =====
// Shared types, constants and the sine table builder for the tone generator.
package stg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SINE_BITS       = 16;

  localparam int MAG_BITS    = SINE_BITS - 1;
  localparam int TABLE_SIZE  = 1 << TABLE_ADDR_BITS;
  localparam int SMAX        = (1 << MAG_BITS) - 1;
  localparam int AMP_BITS    = 11;
  localparam int AMP_LIMIT   = 2000;
  localparam int SAMPLE_OFFSET = 2000;
  localparam int SAMPLE_BITS = 12;
  localparam int FACTOR_BITS = SINE_BITS;
  localparam int PROD_BITS   = AMP_BITS + FACTOR_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int FIELD_PHASE_BITS = 32;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_AMPLITUDE   = 2'd1,
    CFG_STEREO_MODE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                        load_phase;
    logic [FIELD_PHASE_BITS-1:0] phase_value;
    logic                        block_end;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   channel;
    logic                   last;
    logic                   block_end_out;
  } out_word_t;

  // side data riding along with the table read
  typedef struct packed {
    logic neg;
    logic bend;
  } meta_t;

  // finished frame handed to the output stage
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   bend;
  } frame_t;

  typedef logic [MAG_BITS-1:0] sine_rom_t [TABLE_SIZE];

  // Quarter-wave magnitudes, 9th-order Taylor sine in Q30, rounded to SMAX scale.
  function automatic sine_rom_t build_sine_table();
    sine_rom_t   tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    int          k;
    for (k = 0; k < TABLE_SIZE; k++) begin
      x  = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (TABLE_ADDR_BITS + 1);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      tbl[k] = MAG_BITS'((s * 64'(SMAX) + (Q30_ONE >> 1)) >> 30);
    end
    return tbl;
  endfunction

endpackage

// ===== rtl/sine_tone_generator_core.sv =====
// Top level of the DDS sine tone generator: config registers and pipeline control.
//
//   port group   dir   handshake              payload
//   in_*         in    in_valid_i/in_ready_o  in_word_i  (load_phase, phase_value, block_end)
//   out_*        out   out_valid_o/out_ready_i out_word_o (sample, channel, last, block_end_out)
//   cfg_*        in    cfg_we_i               cfg_idx_i, cfg_data_i
//
// Path: accept -> ROM/meta register -> product register -> output register;
// the first register loads on the accepting edge, and out_valid_o rises when
// the output register loads.
// Throughput: one mono frame per cycle while out_ready_i stays high; a stereo frame
// holds the single output register while it sends left then right.
// Reset clears the phase, the config registers and all stage valids.
// Stalls on out_ready_i ripple back through the stage enables to in_ready_o;
// an empty stage always takes a new word.
module sine_tone_generator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  stg_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output stg_pkg::out_word_t                out_word_o,
  input  logic                              cfg_we_i,
  input  logic [stg_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [stg_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  // config registers; amplitude is stored already clamped
  logic [stg_pkg::PHASE_BITS-1:0] step_q, step_d;
  logic [stg_pkg::AMP_BITS-1:0]   amp_q, amp_d;
  logic                           stereo_q, stereo_d;
  logic [stg_pkg::AMP_BITS-1:0]   amp_wr;

  // pipeline control
  logic           v1_q, v1_d;
  logic           v2_q, v2_d;
  logic           en1, en2;
  logic           accept;
  logic           take;
  stg_pkg::meta_t meta_q;
  stg_pkg::meta_t meta_d;

  logic [stg_pkg::TABLE_ADDR_BITS-1:0] rom_addr;
  logic [stg_pkg::MAG_BITS-1:0]        mag;
  stg_pkg::frame_t                     frame;

  // ---------------- configuration ----------------
  assign amp_wr = cfg_data_i[stg_pkg::AMP_BITS-1:0];

  always_comb begin
    step_d   = step_q;
    amp_d    = amp_q;
    stereo_d = stereo_q;
    if (cfg_we_i) begin
      unique case (stg_pkg::cfg_idx_e'(cfg_idx_i))
        stg_pkg::CFG_PHASE_STEP:  step_d = stg_pkg::PHASE_BITS'(cfg_data_i);
        stg_pkg::CFG_AMPLITUDE:
          amp_d = (amp_wr > stg_pkg::AMP_BITS'(stg_pkg::AMP_LIMIT))
                ? stg_pkg::AMP_BITS'(stg_pkg::AMP_LIMIT) : amp_wr;
        stg_pkg::CFG_STEREO_MODE: stereo_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      amp_q    <= '0;
      stereo_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      amp_q    <= amp_d;
      stereo_q <= stereo_d;
    end
  end

  // ---------------- stage control ----------------
  // a stage moves when it is empty or the one after it is moving
  assign en2        = !v2_q || take;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;

  assign v1_d = en1 ? accept : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      meta_q <= meta_d;
    end
  end

  assign meta_d.bend = in_word_i.block_end;

  // ---------------- datapath ----------------
  stg_phase_acc u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .load_i   (in_word_i.load_phase),
    .value_i  (in_word_i.phase_value),
    .step_i   (step_q),
    .addr_o   (rom_addr),
    .neg_o    (meta_d.neg)
  );

  stg_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (en1),
    .addr_i (rom_addr),
    .mag_o  (mag)
  );

  stg_scaler u_scaler (
    .clk_i    (clk_i),
    .en_i     (en2),
    .mag_i    (mag),
    .meta_i   (meta_q),
    .amp_i    (amp_q),
    .stereo_i (stereo_q),
    .frame_o  (frame)
  );

  stg_frame_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (v2_q),
    .frame_i     (frame),
    .stereo_i    (stereo_q),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // ---------------- assertions ----------------
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.sample <= 12'd4001))
    else $error("sample out of range");

  a_right_in_stereo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.channel) |-> stereo_q)
    else $error("right channel word in mono mode");

  a_left_then_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_word_o.last)
      |=> (out_valid_o && out_word_o.channel && out_word_o.last))
    else $error("left word not followed by right word");

  a_bend_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.block_end_out) |-> out_word_o.last)
    else $error("block end flag on a non-final word");

endmodule

// ===== rtl/stg_phase_acc.sv =====
// Phase accumulator with optional load and quarter-wave table addressing.
module stg_phase_acc (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic                                 load_i,
  input  logic [stg_pkg::FIELD_PHASE_BITS-1:0] value_i,
  input  logic [stg_pkg::PHASE_BITS-1:0]       step_i,
  output logic [stg_pkg::TABLE_ADDR_BITS-1:0]  addr_o,
  output logic                                 neg_o
);

  logic [stg_pkg::PHASE_BITS-1:0]      acc_q, acc_d;
  logic [stg_pkg::PHASE_BITS-1:0]      phase;
  logic [1:0]                          quad;
  logic [stg_pkg::TABLE_ADDR_BITS-1:0] idx;

  assign phase = load_i ? stg_pkg::PHASE_BITS'(value_i) : acc_q;
  assign quad  = phase[stg_pkg::PHASE_BITS-1 -: 2];
  assign idx   = phase[stg_pkg::PHASE_BITS-3 -: stg_pkg::TABLE_ADDR_BITS];

  // odd quadrants run the table backwards, the lower half-turn is negative
  assign addr_o = quad[0] ? ~idx : idx;
  assign neg_o  = quad[1];

  assign acc_d = accept_i ? phase + step_i : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== rtl/stg_sine_rom.sv =====
// Quarter-wave sine magnitude ROM with registered read.
module stg_sine_rom (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [stg_pkg::TABLE_ADDR_BITS-1:0] addr_i,
  output logic [stg_pkg::MAG_BITS-1:0]        mag_o
);

  localparam stg_pkg::sine_rom_t SineTable = stg_pkg::build_sine_table();

  logic [stg_pkg::MAG_BITS-1:0] mag_q;

  // holds while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= SineTable[addr_i];
    end
  end

  assign mag_o = mag_q;

endmodule

// ===== rtl/stg_scaler.sv =====
// Amplitude multiply (registered), divide by SMAX and offset to an output code.
module stg_scaler (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [stg_pkg::MAG_BITS-1:0]   mag_i,
  input  stg_pkg::meta_t                 meta_i,
  input  logic [stg_pkg::AMP_BITS-1:0]   amp_i,
  input  logic                           stereo_i,
  output stg_pkg::frame_t                frame_o
);

  localparam int SumBits = stg_pkg::PROD_BITS + 1;

  logic [stg_pkg::FACTOR_BITS-1:0] factor;
  logic [stg_pkg::PROD_BITS-1:0]   prod_q, prod_d;
  logic                            bend_q;
  logic [SumBits-1:0]              v;
  logic [SumBits-1:0]              est_sum;
  logic [stg_pkg::SAMPLE_BITS-1:0] q_est;
  logic [SumBits-1:0]              rem;
  logic [stg_pkg::SAMPLE_BITS-1:0] quo;
  logic [stg_pkg::SAMPLE_BITS:0]   total;

  // shifted non-negative form: amp * (SMAX +/- mag)
  assign factor = meta_i.neg
                ? stg_pkg::FACTOR_BITS'(stg_pkg::SMAX) - stg_pkg::FACTOR_BITS'(mag_i)
                : stg_pkg::FACTOR_BITS'(stg_pkg::SMAX) + stg_pkg::FACTOR_BITS'(mag_i);
  assign prod_d = stg_pkg::PROD_BITS'(amp_i) * stg_pkg::PROD_BITS'(factor);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      bend_q <= meta_i.bend;
    end
  end

  // divide by 2^n-1: series estimate is exact or one low, one fix-up step
  assign v       = SumBits'(prod_q);
  assign est_sum = v + (v >> stg_pkg::MAG_BITS) + (v >> (2 * stg_pkg::MAG_BITS));
  assign q_est   = stg_pkg::SAMPLE_BITS'(est_sum >> stg_pkg::MAG_BITS);
  assign rem     = v - (SumBits'(q_est) << stg_pkg::MAG_BITS) + SumBits'(q_est);
  assign quo     = (rem >= SumBits'(stg_pkg::SMAX)) ? q_est + 1'b1 : q_est;

  assign total = (stg_pkg::SAMPLE_BITS+1)'(stg_pkg::SAMPLE_OFFSET)
               + (stg_pkg::SAMPLE_BITS+1)'(quo)
               - (stg_pkg::SAMPLE_BITS+1)'(amp_i)
               + (stg_pkg::SAMPLE_BITS+1)'(stereo_i);

  assign frame_o.sample = total[stg_pkg::SAMPLE_BITS-1:0];
  assign frame_o.bend   = bend_q;

endmodule

// ===== rtl/stg_frame_out.sv =====
// Output register: sends one word per mono frame, left then right in stereo.
module stg_frame_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  stg_pkg::frame_t    frame_i,
  input  logic               stereo_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stg_pkg::out_word_t out_word_o
);

  logic            valid_q, valid_d;
  logic            chan_q, chan_d;
  stg_pkg::frame_t frame_q;
  logic            last;
  logic            pop;

  assign last   = !stereo_i || chan_q;
  assign pop    = valid_q && out_ready_i;
  assign take_o = !valid_q || (out_ready_i && last);

  always_comb begin
    valid_d = valid_q;
    chan_d  = chan_q;
    if (take_o) begin
      valid_d = load_i;
      chan_d  = 1'b0;
    end else if (pop) begin
      chan_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      chan_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      chan_q  <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && load_i) begin
      frame_q <= frame_i;
    end
  end

  assign out_valid_o              = valid_q;
  assign out_word_o.sample        = frame_q.sample;
  assign out_word_o.channel       = chan_q;
  assign out_word_o.last          = last;
  assign out_word_o.block_end_out = last && frame_q.bend;

endmodule

// ===== tb/sv/sine_tone_generator_core_tb.sv =====
// Self-checking testbench for sine_tone_generator_core: directed table, random frames, scoreboard.
module sine_tone_generator_core_tb;
  import stg_pkg::*;

  // Run control
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_WAIT  = 8;    // pipeline is three stages deep
  localparam int DRAIN_WAIT   = 20;
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int PHASES       = 8;
  localparam int PHASE_FRAMES = 160;
  localparam int MAX_REPORTS  = 40;

  // Index 3 decodes to no register; writes to it must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef logic [PHASE_BITS-1:0]  phase_t;
  typedef logic [SAMPLE_BITS-1:0] code_t;

  // Directed table row: either a register write or one frame request.
  // A frame with has_code set carries its sample value typed in by hand.
  typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_e;
  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [CFG_DATA_BITS-1:0]  data;
    in_word_t                  word;
    logic                      has_code;
    code_t                     code;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;
  logic      cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  sine_tone_generator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the block: registers, phase accumulator, quarter-wave table.
  phase_t             step_reg;
  logic [AMP_BITS-1:0] amp_reg;
  logic               stereo_reg;
  phase_t             phase_now;
  logic [MAG_BITS-1:0] sine_mag [TABLE_SIZE];

  out_word_t expected_words [$];
  dir_row_t  dir_rows [$];
  out_word_t head_word;

  int errors;
  int reports;
  int cycles;
  int frames_sent;
  int stereo_frames;
  int phase_loads;
  int words_checked;
  int settings_used;
  bit hold_req;
  bit hold_done;
  bit burst_mode;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Quarter-wave magnitudes: odd Taylor series to x^9 in Q30, Horner form,
  // truncating products, sampled at the middle of each table slot.
  function automatic void fill_sine_mag();
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] poly;
    logic [63:0] sine_q30;
    logic [63:0] divs [4];
    int          k;
    int          j;
    divs = '{64'd72, 64'd42, 64'd20, 64'd6};
    for (k = 0; k < TABLE_SIZE; k++) begin
      ang    = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (TABLE_ADDR_BITS + 1);
      ang_sq = (ang * ang) >> 30;
      poly   = Q30_ONE;
      for (j = 0; j < 4; j++)
        poly = Q30_ONE - (((ang_sq * poly) >> 30) / divs[j]);
      sine_q30    = (ang * poly) >> 30;
      sine_mag[k] = MAG_BITS'((sine_q30 * 64'(SMAX) + (Q30_ONE >> 1)) >> 30);
    end
  endfunction

  // Offset sample for one phase: quadrant folding, amplitude clamp, floored scale.
  function automatic code_t tone_code(phase_t phase, logic [AMP_BITS-1:0] amp_raw);
    logic [TABLE_ADDR_BITS+1:0] top;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] slot;
    logic [63:0]                amp;
    logic [63:0]                mag;
    logic [63:0]                base;
    logic [63:0]                scaled;
    amp  = (amp_raw > AMP_LIMIT) ? 64'(AMP_LIMIT) : 64'(amp_raw);
    top  = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
    quad = top[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
    slot = top[TABLE_ADDR_BITS-1:0];
    // falling quarters walk the table backward
    if (quad[0])
      slot = TABLE_ADDR_BITS'(TABLE_SIZE - 1) - slot;
    mag  = 64'(sine_mag[slot]);
    base = amp * 64'(SMAX);
    // shifted by amp*SMAX so the floor works on a non-negative value
    if (quad[1])
      scaled = (base - amp * mag) / 64'(SMAX);
    else
      scaled = (base + amp * mag) / 64'(SMAX);
    return SAMPLE_BITS'(64'(SAMPLE_OFFSET) + scaled - amp);
  endfunction

  // Queue the words one accepted frame produces, then advance the phase.
  function automatic void model_frame(in_word_t w, logic has_code, code_t typed_code);
    code_t     code;
    out_word_t o;
    if (w.load_phase) begin
      phase_now = w.phase_value;
      phase_loads++;
    end
    code = has_code ? typed_code : tone_code(phase_now, amp_reg) + code_t'(stereo_reg);
    if (stereo_reg) begin
      // left word never carries the block marker
      o = '{sample: code, channel: 1'b0, last: 1'b0, block_end_out: 1'b0};
      expected_words.push_back(o);
      o = '{sample: code, channel: 1'b1, last: 1'b1, block_end_out: w.block_end};
      expected_words.push_back(o);
      stereo_frames++;
    end else begin
      o = '{sample: code, channel: 1'b0, last: 1'b1, block_end_out: w.block_end};
      expected_words.push_back(o);
    end
    phase_now = phase_now + step_reg;
    frames_sent++;
  endfunction

  function automatic void add_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_frame(logic load, phase_t ph, logic bend, logic has_code, code_t code);
    dir_row_t r;
    r          = '0;
    r.kind     = ROW_FRAME;
    r.word     = '{load_phase: load, phase_value: ph, block_end: bend};
    r.has_code = has_code;
    r.code     = code;
    dir_rows.push_back(r);
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic idle_input(int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Offer one frame and hold it until the block takes it.
  task automatic offer_frame(in_word_t w, logic has_code, code_t typed_code);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_frame(w, has_code, typed_code);
  endtask

  // Registers change only with the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PHASE_STEP:  step_reg   = data;
      CFG_AMPLITUDE:   amp_reg    = data[AMP_BITS-1:0];
      CFG_STEREO_MODE: stereo_reg = data[0];
      default: ;  // spare index: dropped
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // New register setting for one random phase; the first three are corners.
  task automatic random_setup(int p);
    logic [CFG_DATA_BITS-1:0] step_val;
    logic [AMP_BITS-1:0]      amp_val;
    logic                     st_val;
    case (p)
      0: begin step_val = '1; amp_val = AMP_BITS'(AMP_LIMIT); st_val = 1'b1; end
      1: begin step_val = '0; amp_val = '0; st_val = 1'b0; end
      2: begin step_val = $urandom_range(1, 1 << 22); amp_val = '1; st_val = 1'b0; end
      default: begin
        case ($urandom_range(0, 3))
          0: step_val = $urandom;
          1: step_val = $urandom_range(1, 1 << 22);
          2: step_val = 32'h8000_0000 - $urandom_range(0, 1 << 20);
          default: step_val = '1 - $urandom_range(0, 1 << 22);
        endcase
        amp_val = ($urandom_range(0, 3) == 0) ? AMP_BITS'($urandom_range(1990, 2047))
                                             : AMP_BITS'($urandom_range(0, 2047));
        st_val  = 1'($urandom_range(0, 1));
      end
    endcase
    settle();
    write_reg(CFG_PHASE_STEP, step_val);
    // upper data bits are random so the register width masking is exercised
    write_reg(CFG_AMPLITUDE, {21'($urandom), amp_val});
    write_reg(CFG_STEREO_MODE, {31'($urandom), st_val});
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_SPARE, $urandom);
    settings_used++;
  endtask

  task automatic note_mismatch(string field, int want, int got);
    errors++;
    if (reports < MAX_REPORTS) begin
      reports++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, expected_words.size());
      $display("FAIL sine_tone_generator_core");
      $finish;
    end
  end

  // Scoreboard: every accepted output word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected word, expected none, actual %p", $time, out_word_o);
        end
      end else begin
        head_word = expected_words.pop_front();
        words_checked++;
        if (out_word_o.sample !== head_word.sample)
          note_mismatch("sample", int'(head_word.sample), int'(out_word_o.sample));
        if (out_word_o.channel !== head_word.channel)
          note_mismatch("channel", int'(head_word.channel), int'(out_word_o.channel));
        if (out_word_o.last !== head_word.last)
          note_mismatch("last", int'(head_word.last), int'(out_word_o.last));
        if (out_word_o.block_end_out !== head_word.block_end_out)
          note_mismatch("block_end_out", int'(head_word.block_end_out),
                        int'(out_word_o.block_end_out));
      end
    end
  end

  // Receiver: random stalls, stretches of steady ready, and one long hold-off
  // that the stimulus requests so the pipeline backs up into in_ready_o.
  initial begin : ready_gen
    int stall_left;
    int free_left;
    int hold_count;
    stall_left = 0;
    free_left  = 0;
    hold_count = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_count++;
        if (hold_count >= HOLD_CYCLES)
          hold_done = 1'b1;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (free_left > 0)
          free_left--;
        else if ($urandom_range(0, 299) == 0)
          free_left = $urandom_range(100, 300);
        else if ($urandom_range(0, 5) == 0)
          stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    in_word_t w;
    int       p;
    int       n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    step_reg    = '0;
    amp_reg     = '0;
    stereo_reg  = 1'b0;
    phase_now   = '0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    fill_sine_mag();

    // Directed table. Typed samples are the ones that need no arithmetic:
    // zero amplitude puts every sample on the offset (plus one in stereo).
    add_frame(1'b0, 32'h0000_0000, 1'b0, 1'b1, 12'd2000);   // reset state
    add_frame(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 12'd2000);
    add_write(CFG_STEREO_MODE, 32'd1);
    add_frame(1'b0, 32'h0000_0000, 1'b1, 1'b1, 12'd2001);   // stereo offset
    add_write(CFG_AMPLITUDE, 32'hFFFF_FFFF);                 // 2047 clamps
    add_write(CFG_PHASE_STEP, 32'h0010_0000);                // one table slot
    add_frame(1'b1, 32'h0000_0000, 1'b0, 1'b0, '0);
    add_frame(1'b1, 32'h4000_0000, 1'b1, 1'b0, '0);         // quadrant edges
    add_frame(1'b1, 32'h8000_0000, 1'b0, 1'b0, '0);
    add_frame(1'b1, 32'hC000_0000, 1'b0, 1'b0, '0);
    add_frame(1'b0, 32'h0000_0000, 1'b1, 1'b0, '0);
    add_write(CFG_STEREO_MODE, 32'd0);
    add_write(CFG_AMPLITUDE, 32'd2000);
    add_write(CFG_PHASE_STEP, 32'hFFFF_FFFF);                // wraps backward
    add_frame(1'b1, 32'h0000_0000, 1'b0, 1'b0, '0);
    add_frame(1'b0, 32'h0000_0000, 1'b1, 1'b0, '0);
    add_frame(1'b1, 32'h3FFF_FFFF, 1'b0, 1'b0, '0);
    add_write(CFG_SPARE, 32'hFFFF_FFFF);                     // must be ignored
    add_write(CFG_AMPLITUDE, 32'd1);
    add_frame(1'b1, 32'h4000_0000, 1'b0, 1'b0, '0);
    add_frame(1'b1, 32'hC000_0000, 1'b1, 1'b0, '0);         // floor of negative
    add_write(CFG_AMPLITUDE, 32'd0);
    add_frame(1'b1, 32'h8000_0000, 1'b1, 1'b1, 12'd2000);
    add_write(CFG_AMPLITUDE, 32'd2001);                      // just above limit
    add_write(CFG_STEREO_MODE, 32'hFFFF_FFFF);
    add_frame(1'b1, 32'h0000_0000, 1'b0, 1'b0, '0);
    add_frame(1'b0, 32'h0000_0000, 1'b1, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        idle_input(pick_gap());
        offer_frame(dir_rows[i].word, dir_rows[i].has_code, dir_rows[i].code);
      end
    end
    settings_used = 4;

    // Random phases: each gets its own register setting, then a stream of
    // frames. Loads are rare so most frames ride the accumulator.
    for (p = 0; p < PHASES; p++) begin
      random_setup(p);
      burst_mode = (p == 3) || ($urandom_range(0, 3) == 0);
      if (p == 3)
        hold_req = 1'b1;  // receiver freezes while frames keep coming
      for (n = 0; n < PHASE_FRAMES; n++) begin
        w.load_phase  = ($urandom_range(0, 7) == 0);
        w.phase_value = $urandom;
        w.block_end   = ($urandom_range(0, 15) == 0);
        if (!burst_mode || (n % 50) >= 40)
          idle_input(pick_gap());
        offer_frame(w, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d frames (%0d stereo, %0d phase loads) under %0d register settings;",
             frames_sent, stereo_frames, phase_loads, settings_used);
    $display("checked %0d output words, %0d errors.", words_checked, errors);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS sine_tone_generator_core");
    end else begin
      $display("FAIL sine_tone_generator_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/stg_pkg.sv
rtl/stg_phase_acc.sv
rtl/stg_sine_rom.sv
rtl/stg_scaler.sv
rtl/stg_frame_out.sv
rtl/sine_tone_generator_core.sv
tb/sv/sine_tone_generator_core_tb.sv
